// File: src/lls_pkg.sv
// Shared constants and types of the log-linear size mapper.
package lls_pkg;

    localparam int unsigned SECTOR_SHIFT = 9;
    localparam int unsigned SCALE_FLOOR  = 8;
    localparam int unsigned OVF_OCTAVE   = 55;
    localparam int unsigned UNIT_W       = 55;
    localparam int unsigned FRAC_BITS    = 54;
    localparam int unsigned OCT_W        = 6;
    localparam int unsigned LIM_W        = 22;
    localparam int unsigned SCALE_W      = 16;
    localparam int unsigned EXP_STEPS    = 6;
    localparam int unsigned EXP_STAGES   = FRAC_BITS / EXP_STEPS;
    localparam int unsigned QUO_STAGES   = OCT_W / 2;
    localparam int unsigned PIPE_DEPTH   = 3 + QUO_STAGES + EXP_STAGES;

    localparam logic FUNC_TO_POS  = 1'b0;
    localparam logic FUNC_TO_SIZE = 1'b1;

    typedef struct packed {
        logic [SCALE_W-1:0] sc;
        logic [LIM_W-1:0]   lim;
    } t_cfg;

endpackage

// File: src/lls_fwd.sv
// Forward path: byte size to scale position, four register stages.
module lls_fwd (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  lls_pkg::t_cfg              i_cfg,
    input  logic [63:0]                i_value,
    output logic [63:0]                o_pos
);

    logic [lls_pkg::UNIT_W-1:0]    n_u;
    logic [lls_pkg::OCT_W-1:0]     n_p;
    logic [lls_pkg::UNIT_W-1:0]    r_u;
    logic [lls_pkg::OCT_W-1:0]     r_p1;
    logic [lls_pkg::UNIT_W-1:0]    n_dwide;
    logic [lls_pkg::FRAC_BITS-1:0] r_dn;
    logic [lls_pkg::OCT_W-1:0]     r_p2;
    logic [47:0]                   r_ml;
    logic [37:0]                   r_mh;
    logic [21:0]                   r_ps;
    logic [69:0]                   n_sum;
    logic [63:0]                   r_pos;

    // The leading one of the sector count gives the octave.
    always_comb begin
        n_u = i_value[63:lls_pkg::SECTOR_SHIFT];
        n_p = '0;
        for (int i = 0; i < lls_pkg::UNIT_W; i++) begin
            if (n_u[i]) begin
                n_p = lls_pkg::OCT_W'(i);
            end
        end
    end

    // Clearing the leading one and aligning the rest to a fixed fraction point.
    always_comb begin
        n_dwide = (r_u & ~(lls_pkg::UNIT_W'(1) << r_p1))
                  << (lls_pkg::OCT_W'(lls_pkg::FRAC_BITS) - r_p1);
    end

    assign n_sum = {r_mh, 32'b0} + 70'(r_ml);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u   <= n_u;
            r_p1  <= n_p;
            r_dn  <= n_dwide[lls_pkg::FRAC_BITS-1:0];
            r_p2  <= r_p1;
            r_ml  <= r_dn[31:0] * i_cfg.sc;
            r_mh  <= r_dn[53:32] * i_cfg.sc;
            r_ps  <= r_p2 * i_cfg.sc;
            r_pos <= 64'(r_ps) + 64'(n_sum[69:54]);
        end
    end

    assign o_pos = r_pos;

endmodule

// File: src/lls_inv.sv
// Inverse path: scale position to byte size, by pipelined restoring division.
module lls_inv (
    input  logic          i_clk,
    input  logic          i_en,
    input  lls_pkg::t_cfg i_cfg,
    input  logic [63:0]   i_value,
    output logic [63:0]   o_size,
    output logic          o_overflow
);

    localparam int unsigned QS = lls_pkg::QUO_STAGES;
    localparam int unsigned ES = lls_pkg::EXP_STAGES;

    logic                          r_ovf1;
    logic [lls_pkg::LIM_W-1:0]     r_rem1;

    logic                          r_qo [QS];
    logic [lls_pkg::LIM_W-1:0]     r_qr [QS];
    logic [lls_pkg::OCT_W-1:0]     r_qq [QS];

    logic                          r_eo [ES];
    logic [lls_pkg::SCALE_W:0]     r_er [ES];
    logic [lls_pkg::FRAC_BITS-1:0] r_eq [ES];
    logic [lls_pkg::OCT_W-1:0]     r_ep [ES];

    logic [lls_pkg::UNIT_W-1:0]    n_units;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ovf1 <= i_value >= 64'(i_cfg.lim);
            r_rem1 <= i_value[lls_pkg::LIM_W-1:0];
        end
    end

    // Octave: two quotient bits per stage; if no overflow, value < 55 times the scale.
    for (genvar j = 0; j < QS; j++) begin : g_quo
        logic                      p_o;
        logic [lls_pkg::LIM_W-1:0] p_r;
        logic [lls_pkg::OCT_W-1:0] p_q;
        logic [lls_pkg::LIM_W-1:0] n_r;
        logic [lls_pkg::OCT_W-1:0] n_q;
        logic [lls_pkg::LIM_W-1:0] cmp;
        if (j == 0) begin : g_head
            assign p_o = r_ovf1;
            assign p_r = r_rem1;
            assign p_q = '0;
        end else begin : g_tail
            assign p_o = r_qo[j-1];
            assign p_r = r_qr[j-1];
            assign p_q = r_qq[j-1];
        end
        always_comb begin
            cmp = '0;
            n_r = p_r;
            n_q = p_q;
            for (int t = 0; t < 2; t++) begin
                cmp = lls_pkg::LIM_W'(i_cfg.sc) << (lls_pkg::OCT_W - 1 - 2 * j - t);
                if (n_r >= cmp) begin
                    n_r = n_r - cmp;
                    n_q[lls_pkg::OCT_W - 1 - 2 * j - t] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_qo[j] <= p_o;
                r_qr[j] <= n_r;
                r_qq[j] <= n_q;
            end
        end
    end

    // Step within the octave expanded to a 54-bit fraction, six bits per stage.
    for (genvar j = 0; j < ES; j++) begin : g_exp
        logic                          p_o;
        logic [lls_pkg::OCT_W-1:0]     p_p;
        logic [lls_pkg::SCALE_W:0]     p_r;
        logic [lls_pkg::FRAC_BITS-1:0] p_q;
        logic [lls_pkg::SCALE_W:0]     n_r;
        logic [lls_pkg::FRAC_BITS-1:0] n_q;
        if (j == 0) begin : g_head
            assign p_o = r_qo[QS-1];
            assign p_p = r_qq[QS-1];
            assign p_r = (lls_pkg::SCALE_W + 1)'(r_qr[QS-1][lls_pkg::SCALE_W-1:0]);
            assign p_q = '0;
        end else begin : g_tail
            assign p_o = r_eo[j-1];
            assign p_p = r_ep[j-1];
            assign p_r = r_er[j-1];
            assign p_q = r_eq[j-1];
        end
        always_comb begin
            n_r = p_r;
            n_q = p_q;
            for (int t = 0; t < lls_pkg::EXP_STEPS; t++) begin
                n_r = n_r << 1;
                n_q = n_q << 1;
                if (n_r >= (lls_pkg::SCALE_W + 1)'(i_cfg.sc)) begin
                    n_r    = n_r - (lls_pkg::SCALE_W + 1)'(i_cfg.sc);
                    n_q[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_eo[j] <= p_o;
                r_ep[j] <= p_p;
                r_er[j] <= n_r;
                r_eq[j] <= n_q;
            end
        end
    end

    assign n_units = (lls_pkg::UNIT_W'(1) << r_ep[ES-1])
                   + (lls_pkg::UNIT_W'(r_eq[ES-1])
                      >> (lls_pkg::OCT_W'(lls_pkg::FRAC_BITS) - r_ep[ES-1]));

    assign o_overflow = r_eo[ES-1];
    assign o_size     = r_eo[ES-1] ? '1 : {n_units, {lls_pkg::SECTOR_SHIFT{1'b0}}};

endmodule

// File: src/log_linear_size_mapper_top.sv
// Top level of the log-linear size mapper: configuration, pipeline control and output register.
// The mapper converts between a byte size and a position on a piecewise-linear log2 scale
// with slider_scale steps per octave (values below 8 act as 8). A word with func 0 turns a
// size into a position (sizes under one 512-byte sector give 0); func 1 turns a position
// into a size that is a multiple of 512, saturating to all ones with overflow set when the
// octave reaches 55. The block is a 15-stage pipeline: one word may enter every cycle while
// the output side keeps up. The depth is set by the inverse path, a restoring division that
// settles two octave bits per stage and then six bits of the 54-bit in-octave fraction per
// stage. The whole pipeline advances together whenever the output register is empty or
// being read, so a stall at the output holds every word in place. Write slider_scale only
// while no word is in flight.
module log_linear_size_mapper_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [63:0] i_value_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_value_out,
    output logic        o_overflow
);

    localparam int unsigned D = lls_pkg::PIPE_DEPTH;

    lls_pkg::t_cfg r_cfg;
    lls_pkg::t_cfg n_cfg;

    logic          en;
    logic          r_vld [D];
    logic          r_fnc [D-1];
    logic [63:0]   r_val0;
    logic [63:0]   r_fwd_dly [D-6];
    logic [63:0]   fwd_pos;
    logic [63:0]   inv_size;
    logic          inv_ovf;
    logic [63:0]   r_out_val;
    logic          r_out_ovf;
    logic          r_out_func;

    // The effective scale and the overflow limit (55 octaves) are kept ready.
    always_comb begin
        n_cfg.sc  = (i_cfg_data < 16'(lls_pkg::SCALE_FLOOR)) ?
                    16'(lls_pkg::SCALE_FLOOR) : i_cfg_data;
        n_cfg.lim = lls_pkg::LIM_W'(n_cfg.sc) * lls_pkg::LIM_W'(lls_pkg::OVF_OCTAVE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sc  <= 16'(lls_pkg::SCALE_FLOOR);
            r_cfg.lim <= lls_pkg::LIM_W'(lls_pkg::SCALE_FLOOR * lls_pkg::OVF_OCTAVE);
        end else if (i_cfg_we) begin
            r_cfg <= n_cfg;
        end
    end

    assign en         = !r_vld[D-1] || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < D; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int i = 1; i < D; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_val0   <= i_value_in;
            r_fnc[0] <= i_func;
            for (int i = 1; i < D - 1; i++) begin
                r_fnc[i] <= r_fnc[i-1];
            end
            // The forward result is ready at stage four and waits here for the inverse path.
            r_fwd_dly[0] <= fwd_pos;
            for (int i = 1; i < D - 6; i++) begin
                r_fwd_dly[i] <= r_fwd_dly[i-1];
            end
            r_out_func <= r_fnc[D-2];
            if (r_fnc[D-2] == lls_pkg::FUNC_TO_SIZE) begin
                r_out_val <= inv_size;
                r_out_ovf <= inv_ovf;
            end else begin
                r_out_val <= r_fwd_dly[D-7];
                r_out_ovf <= 1'b0;
            end
        end
    end

    lls_fwd u_fwd (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_value (r_val0),
        .o_pos   (fwd_pos)
    );

    lls_inv u_inv (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_cfg      (r_cfg),
        .i_value    (r_val0),
        .o_size     (inv_size),
        .o_overflow (inv_ovf)
    );

    assign o_out_valid = r_vld[D-1];
    assign o_value_out = r_out_val;
    assign o_overflow  = r_out_ovf;

`ifndef SYNTH
    a_ovf_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> o_value_out == '1)
        else $error("overflow without saturated size");
    a_ovf_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_overflow |-> r_out_func == lls_pkg::FUNC_TO_SIZE)
        else $error("overflow on a forward word");
    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_out_func == lls_pkg::FUNC_TO_SIZE && !o_overflow
        |-> o_value_out[8:0] == 9'd0)
        else $error("inverse size not a sector multiple");
    a_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg.sc >= 16'(lls_pkg::SCALE_FLOOR))
        else $error("effective scale below floor");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld[D-2]) && $stable(r_vld[0]))
        else $error("pipeline moved during a stall");
`endif

endmodule

// File: verif/tb.sv
// Self-checking testbench for the log-linear size mapper: directed and random words, scoreboard.
`timescale 1ns / 100ps

class size_map_board;
    logic [63:0] exp_value[$];
    logic        exp_ovf[$];
    logic [15:0] scale_reg;
    int          errors;

    function new();
        scale_reg = 16'd8;
        errors    = 0;
    endfunction

    // Works out the position or size for one accepted word.
    function void note_word(logic func, logic [63:0] v);
        logic [63:0]  sc;
        logic [63:0]  u;
        logic [63:0]  d;
        logic [127:0] wide;
        logic [63:0]  octave;
        logic [63:0]  stepn;
        int           p;
        sc = (scale_reg < 16'd8) ? 64'd8 : {48'd0, scale_reg};
        if (func == lls_pkg::FUNC_TO_POS) begin
            u = v >> 9;
            if (u == 0) begin
                exp_value.push_back(64'd0);
            end else begin
                p = 0;
                for (int i = 0; i < 64; i++) if (u[i]) p = i;
                d = u - (64'd1 << p);
                wide = {64'd0, d} * {64'd0, sc};
                exp_value.push_back(64'(p) * sc + 64'(wide >> p));
            end
            exp_ovf.push_back(1'b0);
        end else begin
            octave = v / sc;
            stepn  = v % sc;
            if (octave >= 55) begin
                exp_value.push_back({64{1'b1}});
                exp_ovf.push_back(1'b1);
            end else begin
                wide = ({64'd0, stepn} << octave) / {64'd0, sc};
                exp_value.push_back(((64'd1 << octave) + 64'(wide)) << 9);
                exp_ovf.push_back(1'b0);
            end
        end
    endfunction

    function bit check_result(logic [63:0] v, logic o, output string why);
        if (exp_value.size() == 0) begin
            why = $sformatf("unexpected result %h", v);
            return 0;
        end
        if (exp_value[0] !== v || exp_ovf[0] !== o) begin
            why = $sformatf("got %h/%b expected %h/%b", v, o, exp_value[0], exp_ovf[0]);
            void'(exp_value.pop_front());
            void'(exp_ovf.pop_front());
            return 0;
        end
        void'(exp_value.pop_front());
        void'(exp_ovf.pop_front());
        return 1;
    endfunction
endclass

module tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = 16'd0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_func = 1'b0;
    logic [63:0] i_value_in = 64'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [63:0] o_value_out;
    logic        o_overflow;

    size_map_board board;
    int          cycles = 0;
    // The receiver is held off for a long stretch while this is set.
    bit          hold_receiver = 0;
    bit          stall_random = 1;

    log_linear_size_mapper_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_func(i_func),
        .i_value_in(i_value_in), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_value_out(o_value_out), .o_overflow(o_overflow)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(string why);
        $display("error at cycle %0d: %s", cycles, why);
        board.errors++;
    endtask

    // The cycle limit covers the slowest correct run many times over.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("log_linear_size_mapper_top: mismatch");
            $finish;
        end
    end

    // Result checking: every accepted result is held against the oldest expectation.
    always @(posedge i_clk) begin
        string why;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (!board.check_result(o_value_out, o_overflow, why)) report_mismatch(why);
        end
    end

    // Receiver stall pattern: long runs of readiness, random stalls, and the long hold-off.
    always @(posedge i_clk) begin
        if (hold_receiver) i_out_ready <= 1'b0;
        else if (!stall_random) i_out_ready <= 1'b1;
        else i_out_ready <= (cycles % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // Offers one word and holds it steady until the handshake completes.
    task automatic send_word(logic func, logic [63:0] v);
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_value_in <= v;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_word(func, v);
    endtask

    task automatic idle_sender();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every expected result has come back, then lets the pipeline drain.
    task automatic drain();
        idle_sender();
        while (board.exp_value.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_scale(logic [15:0] s);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        board.scale_reg = s;
        @(posedge i_clk);
    endtask

    // Random word: half sizes with a random leading one, half positions near the overflow edge.
    task automatic random_word();
        logic [63:0] v;
        logic        f;
        int          sh;
        f  = $urandom_range(0, 1);
        v  = {$urandom, $urandom};
        sh = $urandom_range(0, 63);
        if (f == lls_pkg::FUNC_TO_POS) begin
            if ($urandom_range(0, 3) != 0) v = v >> sh;
        end else begin
            case ($urandom_range(0, 3))
                0: v = 64'($urandom_range(0, 60)) * board.scale_reg + $urandom_range(0, 65535);
                1: v = v >> $urandom_range(0, 63);
                default: v = v % (64'(board.scale_reg < 8 ? 8 : board.scale_reg) * 56);
            endcase
        end
        send_word(f, v);
    endtask

    task automatic random_phase(int n);
        int burst;
        while (n > 0) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && n > 0; i++, n--) random_word();
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) idle_sender();
        end
    endtask

    initial begin
        logic [15:0] scales[6];
        board = new();
        scales = '{16'd0, 16'd5, 16'd65535, 16'd100, 16'd12, 16'd8};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at reset scale: tiny sizes, one sector, extremes, overflow edge.
        stall_random = 0;
        send_word(lls_pkg::FUNC_TO_POS, 64'd0);
        send_word(lls_pkg::FUNC_TO_POS, 64'd511);
        send_word(lls_pkg::FUNC_TO_POS, 64'd512);
        send_word(lls_pkg::FUNC_TO_POS, 64'd1535);
        send_word(lls_pkg::FUNC_TO_POS, {64{1'b1}});
        send_word(lls_pkg::FUNC_TO_POS, 64'h8000_0000_0000_0000);
        send_word(lls_pkg::FUNC_TO_POS, 64'h5555_5555_5555_5555);
        send_word(lls_pkg::FUNC_TO_POS, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(lls_pkg::FUNC_TO_SIZE, 64'd0);
        send_word(lls_pkg::FUNC_TO_SIZE, 64'd7);
        send_word(lls_pkg::FUNC_TO_SIZE, 64'd439);
        send_word(lls_pkg::FUNC_TO_SIZE, 64'd440);
        send_word(lls_pkg::FUNC_TO_SIZE, {64{1'b1}});
        send_word(lls_pkg::FUNC_TO_SIZE, 64'h5555_5555_5555_5555);
        send_word(lls_pkg::FUNC_TO_SIZE, 64'hAAAA_AAAA_AAAA_AAAA);
        // The sender pauses here until every expected result has arrived.
        drain();
        stall_random = 1;

        // Long receiver hold-off while the sender keeps offering, so the input stalls.
        fork
            begin
                hold_receiver = 1;
                repeat (60) @(posedge i_clk);
                hold_receiver = 0;
            end
            random_phase(40);
        join
        drain();

        // Each scale setting, extremes among them, gets its own random phase.
        foreach (scales[k]) begin
            write_scale(scales[k]);
            send_word(lls_pkg::FUNC_TO_SIZE, 64'(scales[k] < 8 ? 8 : scales[k]) * 55 - 1);
            send_word(lls_pkg::FUNC_TO_SIZE, 64'(scales[k] < 8 ? 8 : scales[k]) * 55);
            random_phase(125);
            drain();
        end

        if (board.errors == 0) begin
            $display("log_linear_size_mapper_top: match");
        end else begin
            $display("log_linear_size_mapper_top: mismatch");
        end
        $finish;
    end
endmodule

// File: log_linear_size_mapper_top.f
src/lls_pkg.sv
src/lls_fwd.sv
src/lls_inv.sv
src/log_linear_size_mapper_top.sv
verif/tb.sv
